// ----- hw/rtl/pwn_pkg.sv -----
// Package for the winding-number point-in-polygon block.
// Holds field widths, defaults and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package pwn_pkg;

	localparam int FIELD_BITS       = 16;
	localparam int IDX_BITS         = 5;
	localparam int CNT_BITS         = 6;
	localparam int WIND_BITS        = 7;
	localparam int MIN_VERTICES     = 3;
	localparam int DEF_MAX_VERTICES = 32;
	localparam int DEF_COORD_BITS   = 16;
	localparam int APB_ADDR_BITS    = 3;
	localparam int APB_DATA_BITS    = 32;
	localparam int IN_DATA_BITS     = 40;
	localparam int OUT_DATA_BITS    = 8;

	localparam logic [APB_ADDR_BITS-1:0] REG_VERTEX_COUNT = 3'd0;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_PROBE = 1'b1;

	typedef struct packed {
		logic                wr;
		logic                load_probe;
		logic                rd;
		logic                first;
		logic                close;
		logic [CNT_BITS-1:0] rd_idx;
		logic                out_load;
	} pwn_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} pwn_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pwn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pwn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pwn_ctrl.sv -----
// Controller state machine for the winding-number block.
// Sequences vertex reads, the closing edge, pipeline drain and result hand-off. Uses pwn_pkg.
`default_nettype none

module pwn_ctrl
	import pwn_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CNT_BITS-1:0] vertex_count,
	input  logic                in_valid,
	input  logic                in_func,
	output logic                in_ready,
	input  pwn_stat_t           stat,
	output pwn_cmd_t            cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WALK  = 5'b00010,
		ST_CLOSE = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic [CNT_BITS-1:0] n_eff;
	logic                accept;

	assign n_eff = (32'(vertex_count) > 32'(MAX_VERTICES)) ?
		CNT_BITS'(MAX_VERTICES) : vertex_count;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		cmd            = '0;
		cmd.rd_idx     = cnt_q;
		cmd.first      = (cnt_q == '0);
		case (state_q)
			ST_IDLE: begin
				if (accept && in_func == FUNC_WRITE) begin
					cmd.wr = 1'b1;
				end
				if (accept && in_func == FUNC_PROBE) begin
					cmd.load_probe = 1'b1;
					cnt_d          = '0;
					if (32'(n_eff) < 32'(MIN_VERTICES)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				cmd.rd = 1'b1;
				if (cnt_q == n_eff - CNT_BITS'(1)) begin
					state_d = ST_CLOSE;
				end else begin
					cnt_d = cnt_q + CNT_BITS'(1);
				end
			end
			ST_CLOSE: begin
				cmd.close = 1'b1;
				state_d   = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pwn_dp.sv -----
// Datapath of the winding-number block: vertex RAM, edge pipeline and accumulator.
// Depends on pwn_pkg and pwn_ram.
`default_nettype none

module pwn_dp
	import pwn_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int COORD_BITS   = DEF_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pwn_cmd_t              cmd,
	output pwn_stat_t             stat,
	input  logic [IDX_BITS-1:0]   vertex_index,
	input  logic [FIELD_BITS-1:0] x_coord,
	input  logic [FIELD_BITS-1:0] y_coord,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WIND_BITS-1:0]  winding,
	output logic                  inside_res
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CB = COORD_BITS;
	localparam int DB = COORD_BITS + 1;
	localparam int PB = 2 * DB;
	localparam int LB = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;

	logic signed [CB-1:0] x_in, y_in;
	logic                 we;
	logic [2*CB-1:0]      rdata;

	logic signed [CB-1:0] px_q, py_q;
	logic [2*CB-1:0]      prev_q, first_q;

	logic                 v_s1, first_s1, close_s1;
	logic signed [CB-1:0] x0, y0, x1, y1;
	logic                 edge_v;

	logic                 v_s2, up_s2, dn_s2;
	logic signed [DB-1:0] dx_s2, dyp_s2, dxp_s2, dy_s2;

	logic                 v_s3, up_s3, dn_s3;
	logic signed [PB-1:0] p_s3, q_s3;

	logic signed [WIND_BITS-1:0] acc_q;

	assign x_in = $signed(CB'(x_coord[LB-1:0]));
	assign y_in = $signed(CB'(y_coord[LB-1:0]));
	assign we   = cmd.wr && (32'(vertex_index) < 32'(MAX_VERTICES));

	pwn_ram #(
		.WIDTH (2 * CB),
		.DEPTH (MAX_VERTICES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(vertex_index)),
		.wdata ({y_in, x_in}),
		.re    (cmd.rd),
		.raddr (AW'(cmd.rd_idx)),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_probe) begin
			px_q <= x_in;
			py_q <= y_in;
		end
		if (v_s1 && !close_s1) begin
			prev_q <= rdata;
		end
		if (v_s1 && first_s1 && !close_s1) begin
			first_q <= rdata;
		end
	end

	assign x0 = $signed(prev_q[CB-1:0]);
	assign y0 = $signed(prev_q[2*CB-1:CB]);
	assign x1 = close_s1 ? $signed(first_q[CB-1:0]) : $signed(rdata[CB-1:0]);
	assign y1 = close_s1 ? $signed(first_q[2*CB-1:CB]) : $signed(rdata[2*CB-1:CB]);
	assign edge_v = v_s1 && (close_s1 || !first_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			close_s1 <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			v_s1     <= cmd.rd || cmd.close;
			first_s1 <= cmd.first;
			close_s1 <= cmd.close;
			v_s2     <= edge_v;
			v_s3     <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= DB'(x1) - DB'(x0);
		dyp_s2 <= DB'(py_q) - DB'(y0);
		dxp_s2 <= DB'(px_q) - DB'(x0);
		dy_s2  <= DB'(y1) - DB'(y0);
		up_s2  <= (y0 <= py_q) && (y1 > py_q);
		dn_s2  <= (y0 > py_q) && (y1 <= py_q);
		p_s3   <= dx_s2 * dyp_s2;
		q_s3   <= dxp_s2 * dy_s2;
		up_s3  <= up_s2;
		dn_s3  <= dn_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.load_probe) begin
			acc_q <= '0;
		end else if (v_s3) begin
			if (up_s3 && (p_s3 > q_s3)) begin
				acc_q <= acc_q + WIND_BITS'(1);
			end else if (dn_s3 && (p_s3 < q_s3)) begin
				acc_q <= acc_q - WIND_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			winding    <= acc_q;
			inside_res <= (acc_q != '0);
		end
	end

	assign stat.busy     = v_s1 || v_s2 || v_s3;
	assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/polygon_winding_number_top.sv -----
// Top level of the winding-number point-in-polygon block.
// Holds the vertex-count register and joins pwn_ctrl and pwn_dp. Uses pwn_pkg.
//
// Input words on the s_ stream carry a vertex write (tuser 0) or a probe (tuser 1).
// A vertex write stores the point at vertex_index; it gives no result.
// A probe walks the first n = min(vertex_count, MAX_VERTICES) vertices and gives one word
// on the m_ stream: the winding number and an inside flag.
// With n of three or more, a probe reads the vertices through the single read port of the
// vertex RAM, one vertex per cycle, then sends the closing edge and drains the three-stage
// edge pipeline before it loads the output register; s_tready stays low from acceptance
// until that load, so no new word is taken while a probe is under way. With fewer vertices
// the probe skips the walk and goes straight to loading the output register.
// One result waits in the output register; a write may be accepted while it waits,
// and a following probe finishes its walk but holds in its final cycle until m_tready.
// The user must write vertex_count over APB at byte address 0 only while the block is idle;
// the block does not enforce it. Reset clears the vertex count, control state and output
// valid; the vertex RAM is not cleared, and probing a slot never written gives an unspecified result.
`default_nettype none

module polygon_winding_number_top
	import pwn_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int COORD_BITS   = DEF_COORD_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,  // vertex_index, x_coord, y_coord, zero pad
	input  logic [0:0]               s_tuser,  // func
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,  // winding, inside_res
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	logic [CNT_BITS-1:0]  vc_q;
	pwn_cmd_t             cmd;
	pwn_stat_t            stat;
	logic [WIND_BITS-1:0] winding;
	logic                 inside_res;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_VERTEX_COUNT) ? APB_DATA_BITS'(vc_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == REG_VERTEX_COUNT) begin
			vc_q <= pwdata[CNT_BITS-1:0];
		end
	end

	pwn_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_count (vc_q),
		.in_valid     (s_tvalid),
		.in_func      (s_tuser[0]),
		.in_ready     (s_tready),
		.stat         (stat),
		.cmd          (cmd)
	);

	pwn_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.vertex_index (s_tdata[4:0]),
		.x_coord      (s_tdata[20:5]),
		.y_coord      (s_tdata[36:21]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.winding      (winding),
		.inside_res   (inside_res)
	);

	assign m_tdata = {inside_res, winding};

endmodule

`default_nettype wire

// ----- hw/rtl/pwn_chk.sv -----
// Port-level checker for the winding-number block, bound to the top level.
// Uses pwn_pkg widths.
`default_nettype none

module pwn_chk
	import pwn_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic [0:0]               s_tuser,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_DATA_BITS-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result word changed or dropped while stalled.");

	a_inside_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7] == (m_tdata[6:0] != 7'd0)))
		else $error("Inside flag disagrees with the winding number.");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == FUNC_WRITE && !m_tvalid |=> !m_tvalid)
		else $error("A vertex write produced a result word.");

	a_probe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == FUNC_PROBE |=> !s_tready)
		else $error("Input accepted during a probe.");

endmodule

bind polygon_winding_number_top pwn_chk u_pwn_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ----- dv/winding_checker.sv -----
// Checker for the winding-number point-in-polygon block: watches the input, result and
// APB channels, keeps its own vertex store and vertex count, and scores every result word.
// Uses pwn_pkg for field widths, function codes and the register address.
module winding_checker
	import pwn_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	input  logic [0:0]               s_tuser,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OUT_DATA_BITS-1:0] m_tdata,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	input  logic [APB_DATA_BITS-1:0] prdata,
	input  logic                     pready,
	output int                       fail_count,
	output int                       pending,
	output int                       results_checked,
	output int                       inside_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int X_LSB = IDX_BITS;
	localparam int Y_LSB = IDX_BITS + FIELD_BITS;

	typedef struct packed {
		logic signed [WIND_BITS-1:0] winding;
		logic                        inside_flag;
	} probe_result_t;

	logic [CNT_BITS-1:0]          vertex_count;
	logic signed [FIELD_BITS-1:0] corner_x [DEF_MAX_VERTICES];
	logic signed [FIELD_BITS-1:0] corner_y [DEF_MAX_VERTICES];
	probe_result_t                awaited_results [$];

	function automatic probe_result_t winding_about(longint px, longint py);
		probe_result_t res;
		int n;
		int i;
		int j;
		int wn;
		longint x0;
		longint y0;
		longint x1;
		longint y1;
		longint turn;
		n = (vertex_count > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : int'(vertex_count);
		wn = 0;
		if (n >= MIN_VERTICES) begin
			for (i = 0; i < n; i++) begin
				j = (i + 1 < n) ? i + 1 : 0;
				x0 = corner_x[i];
				y0 = corner_y[i];
				x1 = corner_x[j];
				y1 = corner_y[j];
				turn = (x1 - x0) * (py - y0) - (px - x0) * (y1 - y0);
				if (y0 <= py) begin
					if (y1 > py && turn > 0)
						wn++;
				end else if (y1 <= py && turn < 0) begin
					wn--;
				end
			end
		end
		if (wn > 63)
			wn = 63;
		if (wn < -64)
			wn = -64;
		res.winding     = WIND_BITS'(wn);
		res.inside_flag = (wn != 0);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		probe_result_t seen;
		probe_result_t want;
		if (!arst_n) begin
			vertex_count = '0;
			awaited_results.delete();
		end else begin
			if (psel && penable && pready && paddr == REG_VERTEX_COUNT) begin
				if (pwrite) begin
					vertex_count = pwdata[CNT_BITS-1:0];
				end else if (prdata !== APB_DATA_BITS'(vertex_count)) begin
					fail_count++;
					$display("%0t: vertex_count read back, expected %0d, got %0d",
						$time, vertex_count, prdata);
				end
			end
			if (m_tvalid && m_tready) begin
				seen.winding     = m_tdata[WIND_BITS-1:0];
				seen.inside_flag = m_tdata[WIND_BITS];
				if (awaited_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result word, expected none, got winding %0d inside %0b",
						$time, seen.winding, seen.inside_flag);
				end else begin
					want = awaited_results.pop_front();
					results_checked++;
					if (want.inside_flag)
						inside_count++;
					if (seen !== want) begin
						fail_count++;
						$display("%0t: expected winding %0d inside %0b, got winding %0d inside %0b",
							$time, want.winding, want.inside_flag, seen.winding,
							seen.inside_flag);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == FUNC_PROBE) begin
					awaited_results = {awaited_results, winding_about(
						$signed(s_tdata[X_LSB +: FIELD_BITS]),
						$signed(s_tdata[Y_LSB +: FIELD_BITS]))};
				end else begin
					corner_x[s_tdata[IDX_BITS-1:0]] = s_tdata[X_LSB +: FIELD_BITS];
					corner_y[s_tdata[IDX_BITS-1:0]] = s_tdata[Y_LSB +: FIELD_BITS];
				end
			end
		end
		pending = awaited_results.size();
	end

endmodule

// ----- dv/polygon_winding_number_top_tb.sv -----
// Testbench top for polygon_winding_number_top: clock, reset, vertex and probe words,
// APB vertex-count setup, random receiver stalls and the final verdict.
// Uses pwn_pkg and the winding_checker module, which scores every result word.
module polygon_winding_number_top_tb
	import pwn_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET    = 550;
	localparam int DRAIN_CYCLES   = DEF_MAX_VERTICES + 10;
	localparam int WATCHDOG_LIMIT = 4000;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;  // vertex_index, x_coord, y_coord, zero pad
	logic [0:0]               s_tuser;  // func
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;  // winding, inside_res
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int fail_count;
	int pending;
	int results_checked;
	int inside_count;
	int items_sent;
	int writes_sent;
	int probes_sent;
	int count_settings;
	int burst_left;
	int idle_cycles;

	polygon_winding_number_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	winding_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.inside_count    (inside_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int seg_left;
		int mode;
		m_tready = 1'b0;
		seg_left = 0;
		mode     = 0;
		forever begin
			@(negedge clk);
			if (seg_left == 0) begin
				mode     = $urandom_range(0, 3);
				seg_left = $urandom_range(16, 80);
			end
			seg_left--;
			case (mode)
				0: m_tready = 1'b1;
				1: m_tready = $urandom_range(0, 1);
				2: m_tready = ($urandom_range(0, 7) == 0);
				default: m_tready = !m_tready;
			endcase
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("No word moved for %0d cycles, stopping.", idle_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic logic signed [FIELD_BITS-1:0] rand_coord(int scale);
		int v;
		case (scale)
			0: v = $urandom_range(0, 65535);
			1: v = $urandom_range(0, 16) - 8;
			2: begin
				case ($urandom_range(0, 3))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: v = $urandom_range(0, 2000) - 1000;
		endcase
		return FIELD_BITS'(v);
	endfunction

	task automatic send_word(logic func, logic [IDX_BITS-1:0] idx,
			logic signed [FIELD_BITS-1:0] x, logic signed [FIELD_BITS-1:0] y);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tdata  = IN_DATA_BITS'({y, x, idx});
		s_tuser  = func;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		if (func == FUNC_PROBE)
			probes_sent++;
		else
			writes_sent++;
	endtask

	task automatic apb_access(logic write, logic [APB_DATA_BITS-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = write;
		paddr   = REG_VERTEX_COUNT;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// The block must be idle before the count changes: no result outstanding and
	// any trailing vertex write or probe walk long finished.
	task automatic set_vertex_count(int value);
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		apb_access(1'b1, APB_DATA_BITS'(value));
		apb_access(1'b0, '0);
		count_settings++;
	endtask

	initial begin
		int phase;
		int count;
		int n;
		int scale;
		int shape;
		int half;
		int c;
		int i;
		logic dir;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		burst_left = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// An empty polygon straight after reset.
		send_word(FUNC_PROBE, 5'd0, 16'sd0, 16'sd0);
		send_word(FUNC_PROBE, 5'd31, -16'sd32768, 16'sd32767);
		send_word(FUNC_WRITE, 5'd0, -16'sd32768, -16'sd32768);
		send_word(FUNC_WRITE, 5'd1, 16'sd32767, -16'sd32768);
		send_word(FUNC_WRITE, 5'd2, 16'sd0, 16'sd32767);

		// One and two vertices still give an empty polygon.
		set_vertex_count(1);
		send_word(FUNC_PROBE, 5'd0, 16'sd0, 16'sd0);
		set_vertex_count(2);
		send_word(FUNC_PROBE, 5'd3, 16'sd5, -16'sd3);

		// Full-range triangle: inside, on a vertex, outside and on the bottom edge.
		set_vertex_count(3);
		send_word(FUNC_PROBE, 5'd0, 16'sd0, 16'sd0);
		send_word(FUNC_PROBE, 5'd0, -16'sd32768, -16'sd32768);
		send_word(FUNC_PROBE, 5'd0, 16'sd32767, 16'sd32767);
		send_word(FUNC_PROBE, 5'd0, 16'sd0, -16'sd32768);
		send_word(FUNC_PROBE, 5'd0, -16'sd32768, 16'sd32767);

		// A pentagram winds twice around its center.
		set_vertex_count(5);
		send_word(FUNC_WRITE, 5'd0, 16'sd0, 16'sd30000);
		send_word(FUNC_WRITE, 5'd1, -16'sd17700, -16'sd24300);
		send_word(FUNC_WRITE, 5'd2, 16'sd28500, 16'sd9300);
		send_word(FUNC_WRITE, 5'd3, -16'sd28500, 16'sd9300);
		send_word(FUNC_WRITE, 5'd4, 16'sd17700, -16'sd24300);
		send_word(FUNC_PROBE, 5'd0, 16'sd0, 16'sd0);
		send_word(FUNC_PROBE, 5'd0, 16'sd0, 16'sd25000);
		send_word(FUNC_PROBE, 5'd0, 16'sd30000, -16'sd30000);
		send_word(FUNC_WRITE, 5'd31, 16'sd32767, -16'sd1);

		// Each phase sets a count, lays down a complete polygon, then mixes probes
		// with stray vertex rewrites.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: count = DEF_MAX_VERTICES;
				1: count = 63;
				2: count = 0;
				default: begin
					c = $urandom_range(0, 19);
					if (c == 0)
						count = $urandom_range(0, 2);
					else if (c == 1)
						count = $urandom_range(DEF_MAX_VERTICES, 63);
					else
						count = $urandom_range(3, 10);
				end
			endcase
			set_vertex_count(count);
			n     = (count > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : count;
			scale = $urandom_range(0, 3);
			shape = $urandom_range(0, 2);
			dir   = $urandom_range(0, 1);
			case (scale)
				0: half = $urandom_range(1, 32767);
				1: half = $urandom_range(1, 8);
				2: half = 32767;
				default: half = $urandom_range(1, 1000);
			endcase
			for (i = 0; i < n; i++) begin
				if (shape == 0) begin
					send_word(FUNC_WRITE, IDX_BITS'(i), rand_coord(scale), rand_coord(scale));
				end else begin
					c = dir ? 3 - (i % 4) : i % 4;
					send_word(FUNC_WRITE, IDX_BITS'(i),
						FIELD_BITS'((c == 1 || c == 2) ? half : -half),
						FIELD_BITS'((c >= 2) ? half : -half));
				end
			end
			repeat ($urandom_range(8, 30)) begin
				if ($urandom_range(0, 4) == 0)
					send_word(FUNC_WRITE, IDX_BITS'($urandom_range(0, 31)),
						rand_coord(scale), rand_coord(scale));
				else
					send_word(FUNC_PROBE, IDX_BITS'($urandom_range(0, 31)),
						rand_coord(scale), rand_coord(scale));
			end
			phase++;
		end

		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d vertex writes and %0d probes across %0d vertex-count settings.",
			writes_sent, probes_sent, count_settings);
		$display("Scored %0d result words, %0d of them with the point inside.",
			results_checked, inside_count);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- polygon_winding_number_top.f -----
hw/rtl/pwn_pkg.sv
hw/rtl/pwn_ram.sv
hw/rtl/pwn_ctrl.sv
hw/rtl/pwn_dp.sv
hw/rtl/polygon_winding_number_top.sv
hw/rtl/pwn_chk.sv
dv/winding_checker.sv
dv/polygon_winding_number_top_tb.sv
